FILE: sv/srtl_pkg.sv
// Package for the sorted region table lookup block.
// Holds request kinds, status codes and the structs passed between the top level and its cells.
// No dependencies.
`timescale 1ns / 1ps

package srtl_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // Response status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_OVERLAP = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   // Control from the sequencer to every cell.
   typedef struct packed {
      logic eval;     // register the comparisons against the held request
      logic shift_in; // commit an accepted insert: load or shift
   } cell_ctrl_type;

   // Per-cell result flags back to the top level.
   typedef struct packed {
      logic hit;      // lookup address lies inside this cell's region
      logic overlap;  // insert candidate overlaps this cell's region
   } cell_stat_type;

endpackage

FILE: sv/srtl_cell.sv
// One cell of the sorted region table: a region plus its comparators.
// Depends on srtl_pkg for the control and status structs.
`timescale 1ns / 1ps

module srtl_cell #(
   parameter int ADDR_WIDTH = 39,
   parameter int CNT_WIDTH  = 5,
   parameter int INDEX      = 0
) (
   input  logic                          clock,
   input  srtl_pkg::cell_ctrl_type       ctrl,
   input  logic [ADDR_WIDTH-1:0]         req_address,
   input  logic [ADDR_WIDTH-1:0]         req_region_end,
   input  logic [7:0]                    req_region_flags,
   input  logic [CNT_WIDTH-1:0]          used_count,
   input  logic                          left_le,
   input  logic [ADDR_WIDTH-1:0]         left_start,
   input  logic [ADDR_WIDTH-1:0]         left_end,
   input  logic [7:0]                    left_flags,
   input  logic                          right_le,
   output logic                          le,
   output logic [ADDR_WIDTH-1:0]         cell_start,
   output logic [ADDR_WIDTH-1:0]         cell_end,
   output logic [7:0]                    cell_flags,
   output srtl_pkg::cell_stat_type       stat
);

   logic                  active;
   logic                  le_ff, le_in;
   logic                  below_ff, below_in;
   logic                  eover_ff, eover_in;
   logic [ADDR_WIDTH-1:0] start_ff, start_in;
   logic [ADDR_WIDTH-1:0] end_ff, end_in;
   logic [7:0]            flags_ff, flags_in;

   assign active = CNT_WIDTH'(INDEX) < used_count;

   always_comb begin
      le_in    = le_ff;
      below_in = below_ff;
      eover_in = eover_ff;
      if (ctrl.eval) begin
         le_in    = active && (start_ff <= req_address);
         below_in = active && (req_address < end_ff);
         eover_in = active && (req_region_end > start_ff);
      end
   end

   // Cells before the insert point keep their region, the cell at it takes the
   // new one and every cell after it takes its left neighbour's region.
   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      flags_in = flags_ff;
      if (ctrl.shift_in && !le_ff) begin
         if (left_le) begin
            start_in = req_address;
            end_in   = req_region_end;
            flags_in = req_region_flags;
         end else begin
            start_in = left_start;
            end_in   = left_end;
            flags_in = left_flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      le_ff    <= le_in;
      below_ff <= below_in;
      eover_ff <= eover_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      flags_ff <= flags_in;
   end

   assign le         = le_ff;
   assign cell_start = start_ff;
   assign cell_end   = end_ff;
   assign cell_flags = flags_ff;

   // The last region at or below the new start must end at or before it; the
   // first region above the new start must begin at or after the new end.
   assign stat.hit     = le_ff && below_ff;
   assign stat.overlap = (le_ff && !right_le && below_ff) || (!le_ff && left_le && eover_ff);

endmodule

FILE: sv/sorted_region_table_lookup_top.sv
// Top level of the sorted region table lookup block.
// Depends on srtl_pkg and instantiates a row of srtl_cell.
`timescale 1ns / 1ps

// The block holds up to MAX_REGIONS non-overlapping address regions in a row of
// cells kept sorted by start address. A request is taken when start is high and
// busy is low; busy then stays high through the sequencer's latch state, in which the
// taken request sits in its registers, its eval state, in which every cell compares
// its region against it, and its apply state, in which the cell flags are combined, an
// insert shifts the row by one place and the response is registered. The response is
// shown on the rsp_ ports for one cycle, marked by rsp_valid, in the cycle after that;
// it cannot be held off, and a new request may be given in that same cycle but not
// before it, so requests are served one at a time. Every request gets exactly one
// response. A lookup reports the matching region or a miss; an insert reports ok, an
// empty or inverted range, an overlap with a neighbour, or a full table, in that order
// of precedence, and leaves the table untouched on any refusal; a clear empties the
// table; the unused kind changes nothing. rsp_entries_used always gives the number of
// regions held after the request. Region storage needs no clearing after reset.
// Because every cell is searched in parallel, no last-hit copy is kept.
module sorted_region_table_lookup_top #(
   parameter int MAX_REGIONS = 16,
   parameter int ADDR_WIDTH  = 39
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_kind,
   input  logic [ADDR_WIDTH-1:0]                req_address,
   input  logic [ADDR_WIDTH-1:0]                req_region_end,
   input  logic [7:0]                           req_region_flags,
   output logic                                 rsp_valid,
   output logic                                 rsp_found,
   output logic [ADDR_WIDTH-1:0]                rsp_hit_start,
   output logic [ADDR_WIDTH-1:0]                rsp_hit_end,
   output logic [7:0]                           rsp_hit_flags,
   output logic [1:0]                           rsp_status,
   output logic [$clog2(MAX_REGIONS+1)-1:0]     rsp_entries_used
);

   localparam int CntWidth = $clog2(MAX_REGIONS + 1);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LATCH = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;
   localparam logic [1:0] ST_APPLY = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  valid_ff, valid_in;

   // Held request.
   logic [1:0]            kind_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic [ADDR_WIDTH-1:0] rend_ff;
   logic [7:0]            rflags_ff;

   // Held response.
   logic                  found_ff, found_in;
   logic [ADDR_WIDTH-1:0] hstart_ff, hstart_in;
   logic [ADDR_WIDTH-1:0] hend_ff, hend_in;
   logic [7:0]            hflags_ff, hflags_in;
   logic [1:0]            status_ff, status_in;

   logic                  accept;
   logic                  insert_go;
   srtl_pkg::cell_ctrl_type ctrl;

   logic [MAX_REGIONS-1:0]  le_vec;
   logic [ADDR_WIDTH-1:0]   start_vec [MAX_REGIONS];
   logic [ADDR_WIDTH-1:0]   end_vec   [MAX_REGIONS];
   logic [7:0]              flags_vec [MAX_REGIONS];
   srtl_pkg::cell_stat_type stat_vec  [MAX_REGIONS];

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // The row of cells. The first cell sees a left neighbour that lies at or
   // below any start, so it takes a new region when its own does not; the last
   // cell sees a right neighbour that never does.
   for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
      logic                  left_le;
      logic [ADDR_WIDTH-1:0] left_start;
      logic [ADDR_WIDTH-1:0] left_end;
      logic [7:0]            left_flags;
      logic                  right_le;

      if (i == 0) begin : g_first
         assign left_le    = 1'b1;
         assign left_start = '0;
         assign left_end   = '0;
         assign left_flags = '0;
      end else begin : g_inner
         assign left_le    = le_vec[i-1];
         assign left_start = start_vec[i-1];
         assign left_end   = end_vec[i-1];
         assign left_flags = flags_vec[i-1];
      end

      if (i == MAX_REGIONS - 1) begin : g_last
         assign right_le = 1'b0;
      end else begin : g_mid
         assign right_le = le_vec[i+1];
      end

      srtl_cell #(
         .ADDR_WIDTH (ADDR_WIDTH),
         .CNT_WIDTH  (CntWidth),
         .INDEX      (i)
      ) u_cell (
         .clock            (clock),
         .ctrl             (ctrl),
         .req_address      (addr_ff),
         .req_region_end   (rend_ff),
         .req_region_flags (rflags_ff),
         .used_count       (count_ff),
         .left_le          (left_le),
         .left_start       (left_start),
         .left_end         (left_end),
         .left_flags       (left_flags),
         .right_le         (right_le),
         .le               (le_vec[i]),
         .cell_start       (start_vec[i]),
         .cell_end         (end_vec[i]),
         .cell_flags       (flags_vec[i]),
         .stat             (stat_vec[i])
      );
   end

   // Combine the registered cell flags. Stored regions never overlap, so at
   // most one cell reports a hit and an OR of the gated fields selects it.
   always_comb begin
      logic                  any_hit;
      logic                  any_ovl;
      logic [ADDR_WIDTH-1:0] sel_start;
      logic [ADDR_WIDTH-1:0] sel_end;
      logic [7:0]            sel_flags;
      any_hit   = 1'b0;
      any_ovl   = 1'b0;
      sel_start = '0;
      sel_end   = '0;
      sel_flags = '0;
      for (int i = 0; i < MAX_REGIONS; i++) begin
         any_hit   = any_hit | stat_vec[i].hit;
         any_ovl   = any_ovl | stat_vec[i].overlap;
         sel_start = sel_start | (stat_vec[i].hit ? start_vec[i] : '0);
         sel_end   = sel_end   | (stat_vec[i].hit ? end_vec[i]   : '0);
         sel_flags = sel_flags | (stat_vec[i].hit ? flags_vec[i] : '0);
      end

      found_in  = 1'b0;
      hstart_in = '0;
      hend_in   = '0;
      hflags_in = '0;
      status_in = srtl_pkg::STATUS_OK;
      insert_go = 1'b0;
      count_in  = count_ff;

      case (kind_ff)
         srtl_pkg::KIND_LOOKUP: begin
            found_in  = any_hit;
            hstart_in = sel_start;
            hend_in   = sel_end;
            hflags_in = sel_flags;
         end
         srtl_pkg::KIND_INSERT: begin
            if (!(addr_ff < rend_ff)) begin
               status_in = srtl_pkg::STATUS_EMPTY;
            end else if (any_ovl) begin
               status_in = srtl_pkg::STATUS_OVERLAP;
            end else if (count_ff == CntWidth'(MAX_REGIONS)) begin
               status_in = srtl_pkg::STATUS_FULL;
            end else begin
               insert_go = (state_ff == ST_APPLY);
               count_in  = count_ff + CntWidth'(1);
            end
         end
         srtl_pkg::KIND_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign ctrl.eval     = (state_ff == ST_EVAL);
   assign ctrl.shift_in = insert_go;

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LATCH;
            end
         end
         ST_LATCH: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
            valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (state_ff == ST_APPLY) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind;
         addr_ff   <= req_address;
         rend_ff   <= req_region_end;
         rflags_ff <= req_region_flags;
      end
      if (state_ff == ST_APPLY) begin
         found_ff  <= found_in;
         hstart_ff <= hstart_in;
         hend_ff   <= hend_in;
         hflags_ff <= hflags_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_hit_start    = hstart_ff;
   assign rsp_hit_end      = hend_ff;
   assign rsp_hit_flags    = hflags_ff;
   assign rsp_status       = status_ff;
   assign rsp_entries_used = count_ff;

endmodule

FILE: sv/srtl_checker.sv
// Port-level checker for the sorted region table lookup block, bound to its top level.
// Depends on srtl_pkg for the status codes.
`timescale 1ns / 1ps

module srtl_checker #(
   parameter int MAX_REGIONS = 16,
   parameter int ADDR_WIDTH  = 39
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic                                rsp_found,
   input logic [ADDR_WIDTH-1:0]               rsp_hit_start,
   input logic [ADDR_WIDTH-1:0]               rsp_hit_end,
   input logic [1:0]                          rsp_status,
   input logic [$clog2(MAX_REGIONS+1)-1:0]    rsp_entries_used
);

   localparam int CntWidth = $clog2(MAX_REGIONS + 1);

   // Every accepted request gets its response once the block has passed its latch, eval and apply states.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("response not returned four cycles after request");

   // A response only ever appears once the block has gone idle again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   // A hit is a real, non-empty region and carries an ok status.
   a_hit_sane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         (rsp_hit_start < rsp_hit_end) && (rsp_status == srtl_pkg::STATUS_OK))
      else $error("hit with empty region or error status");

   // The fill level never exceeds the table size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entries_used <= CntWidth'(MAX_REGIONS)))
      else $error("entry count beyond table size");

   // A full-table refusal is only ever reported with every entry in use.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == srtl_pkg::STATUS_FULL) |->
         (rsp_entries_used == CntWidth'(MAX_REGIONS)))
      else $error("table full reported below capacity");

endmodule

bind sorted_region_table_lookup_top srtl_checker #(
   .MAX_REGIONS (MAX_REGIONS),
   .ADDR_WIDTH  (ADDR_WIDTH)
) u_srtl_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_found        (rsp_found),
   .rsp_hit_start    (rsp_hit_start),
   .rsp_hit_end      (rsp_hit_end),
   .rsp_status       (rsp_status),
   .rsp_entries_used (rsp_entries_used)
);
